// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition is never true outside of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== design/mmf_pkg.sv =====
// ---------------------------------------------------------------------------
// Fixed-point matrix multiply package
// Types, codes and defaults shared by the controller, datapath and top level.
// ---------------------------------------------------------------------------
package mmf_pkg;

  // Default bounds of the block.
  localparam int MMF_MAX_DIM      = 32;
  localparam int MMF_ELEMENT_BITS = 16;

  // Configuration register widths and indexes.
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
  localparam logic [CFG_W-1:0]     CFG_RESET     = 6'd32;

  // Command kinds.
  localparam logic [1:0] KIND_WRITE_A = 2'd0;
  localparam logic [1:0] KIND_WRITE_B = 2'd1;
  localparam logic [1:0] KIND_READ_C  = 2'd2;

  // Saturation limits of the Q16.16 result.
  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] element_value;
  } mmf_in_t;

  typedef struct packed {
    logic signed [31:0] product_value;
    logic               index_error;
  } mmf_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_cmd;
    logic mem_write;
    logic acc_clear;
    logic issue;
    logic load_result;
    logic use_acc;
  } mmf_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       cmd_err;
    logic       k_last;
    logic       k_zero;
    logic       pipe_busy;
  } mmf_sts_t;

endpackage

// ===== design/mmf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Matrix multiply controller
// Sequences decode, the inner-product walk, pipeline drain and the result.
// ---------------------------------------------------------------------------
module mmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output mmf_pkg::mmf_ctrl_t ctrl_o,
  input  mmf_pkg::mmf_sts_t  sts_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.load_cmd = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.kind) inside
          mmf_pkg::KIND_WRITE_A, mmf_pkg::KIND_WRITE_B: begin
            ctrl_o.mem_write   = 1'b1;
            ctrl_o.load_result = 1'b1;
            state_d            = S_RESP;
          end
          mmf_pkg::KIND_READ_C: begin
            if (sts_i.cmd_err) begin
              ctrl_o.load_result = 1'b1;
              state_d            = S_RESP;
            end else begin
              ctrl_o.acc_clear = 1'b1;
              state_d          = sts_i.k_zero ? S_DRAIN : S_RUN;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RUN: begin
        ctrl_o.issue = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          ctrl_o.load_result = 1'b1;
          ctrl_o.use_acc     = 1'b1;
          state_d            = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESP);

endmodule

// ===== design/mmf_datapath.sv =====
// ---------------------------------------------------------------------------
// Matrix multiply datapath
// Size registers, element stores, multiply-accumulate pipeline and result.
// ---------------------------------------------------------------------------
module mmf_datapath #(
  parameter int MAX_DIM      = mmf_pkg::MMF_MAX_DIM,
  parameter int ELEMENT_BITS = mmf_pkg::MMF_ELEMENT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mmf_pkg::CFG_W-1:0]     cfg_data_i,
  input  mmf_pkg::mmf_in_t              cmd_i,
  input  mmf_pkg::mmf_ctrl_t            ctrl_i,
  output mmf_pkg::mmf_sts_t             sts_o,
  output mmf_pkg::mmf_out_t             result_o
);

  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int PROD_W  = 2 * ELEMENT_BITS;
  localparam int SUM_W   = PROD_W + IDX_W + 1;
  localparam int ACC_W   = (SUM_W > 33) ? SUM_W : 33;
  localparam int CW      = mmf_pkg::CFG_W;

  // Size registers.
  logic [CW-1:0] rows_a_q, inner_dim_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= mmf_pkg::CFG_RESET;
      inner_dim_q <= mmf_pkg::CFG_RESET;
      cols_b_q    <= mmf_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mmf_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        mmf_pkg::CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        mmf_pkg::CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes above the bound act as the bound.
  logic [CW-1:0] na, nk, nb;
  assign na = (32'(rows_a_q)    > MAX_DIM) ? CW'(MAX_DIM) : rows_a_q;
  assign nk = (32'(inner_dim_q) > MAX_DIM) ? CW'(MAX_DIM) : inner_dim_q;
  assign nb = (32'(cols_b_q)    > MAX_DIM) ? CW'(MAX_DIM) : cols_b_q;

  // Latched command word.
  mmf_pkg::mmf_in_t cmd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_cmd) begin
      cmd_q <= cmd_i;
    end
  end

  logic [CW-1:0] row_ext, col_ext;
  logic          cmd_err;
  assign row_ext = {1'b0, cmd_q.row_index};
  assign col_ext = {1'b0, cmd_q.col_index};

  always_comb begin
    unique case (cmd_q.kind)
      mmf_pkg::KIND_WRITE_A: cmd_err = (row_ext >= na) || (col_ext >= nk);
      mmf_pkg::KIND_WRITE_B: cmd_err = (row_ext >= nk) || (col_ext >= nb);
      mmf_pkg::KIND_READ_C:  cmd_err = (row_ext >= na) || (col_ext >= nb);
      default:               cmd_err = 1'b0;
    endcase
  end

  // Inner index counter.
  logic [IDX_W-1:0] k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (ctrl_i.acc_clear) begin
      k_q <= '0;
    end else if (ctrl_i.issue) begin
      k_q <= k_q + 1'b1;
    end
  end

  // Element stores, each with one write port and one read port.
  logic [IDX_W-1:0]        row_idx, col_idx;
  logic [31:0]             value_ext;
  logic [ELEMENT_BITS-1:0] wdata;
  logic                    a_we, b_we;
  logic [ADDR_W-1:0]       waddr, a_raddr, b_raddr;

  assign row_idx   = IDX_W'(cmd_q.row_index);
  assign col_idx   = IDX_W'(cmd_q.col_index);
  assign value_ext = {{16{cmd_q.element_value[15]}}, cmd_q.element_value};
  assign wdata     = value_ext[ELEMENT_BITS-1:0];
  assign waddr     = {row_idx, col_idx};
  assign a_raddr   = {row_idx, k_q};
  assign b_raddr   = {k_q, col_idx};
  assign a_we      = ctrl_i.mem_write && !cmd_err && (cmd_q.kind == mmf_pkg::KIND_WRITE_A);
  assign b_we      = ctrl_i.mem_write && !cmd_err && (cmd_q.kind == mmf_pkg::KIND_WRITE_B);

  logic [ELEMENT_BITS-1:0] a_mem [DEPTH];
  logic [ELEMENT_BITS-1:0] b_mem [DEPTH];
  logic signed [ELEMENT_BITS-1:0] a_rdata_q, b_rdata_q;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[waddr] <= wdata;
    end
    a_rdata_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[waddr] <= wdata;
    end
    b_rdata_q <= b_mem[b_raddr];
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate.
  logic                     rd_valid_q, mul_valid_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      mul_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= ctrl_i.issue;
      mul_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_rdata_q * b_rdata_q;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clear) begin
      acc_d = '0;
    end else if (mul_valid_q) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Saturation to 32 bits: the sum fits when the bits from 31 up all agree.
  logic [ACC_W-32:0] acc_hi;
  logic              acc_fits;
  logic [31:0]       sat_value;

  assign acc_hi    = acc_q[ACC_W-1:31];
  assign acc_fits  = (&acc_hi) || !(|acc_hi);
  assign sat_value = acc_fits ? acc_q[31:0] :
                     (acc_q[ACC_W-1] ? mmf_pkg::SAT_MIN : mmf_pkg::SAT_MAX);

  mmf_pkg::mmf_out_t result_q, result_d;

  always_comb begin
    result_d.index_error   = cmd_err;
    result_d.product_value = (ctrl_i.use_acc && !cmd_err) ? sat_value : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_result) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

  assign sts_o.kind      = cmd_q.kind;
  assign sts_o.cmd_err   = cmd_err;
  assign sts_o.k_last    = ((32'(k_q) + 32'd1) == 32'(nk));
  assign sts_o.k_zero    = (nk == '0);
  assign sts_o.pipe_busy = rd_valid_q || mul_valid_q;

endmodule

// ===== design/matrix_multiply_fixed.sv =====
// ---------------------------------------------------------------------------
// Fixed-point matrix multiply
// Element stores for A and B and a multiply-accumulate read of C = A x B.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake                        Payload
//   command   start_i high while busy_o low    cmd_i (mmf_in_t)
//   result    result_valid_o, one cycle        result_o (mmf_out_t)
//   config    cfg_valid_i and cfg_ready_o      cfg_index_i, cfg_data_i
//
// A write word or a rejected word passes through DECODE and strobes its result
// in RESP, and the block takes the next word once it is back in IDLE.
// A read of C passes DECODE, RUN and DRAIN before its RESP strobe (RUN is skipped
// with a zero inner dimension): one multiply-accumulate per cycle in RUN, paced by
// the single read port of each element store, then DRAIN lets the pipeline empty.
// Reset sets the three size registers to 32; the stores are not cleared.
// The result receiver cannot stall, and configuration words are always taken.
//
// The controller walks the inner index and the datapath holds the stores,
// the product register and a wide accumulator that saturates into a Q16.16
// result register.
`include "assert_macros.svh"

module matrix_multiply_fixed #(
  parameter int MAX_DIM      = mmf_pkg::MMF_MAX_DIM,
  parameter int ELEMENT_BITS = mmf_pkg::MMF_ELEMENT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  mmf_pkg::mmf_in_t              cmd_i,
  output logic                          result_valid_o,
  output mmf_pkg::mmf_out_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mmf_pkg::CFG_W-1:0]     cfg_data_i
);

  mmf_pkg::mmf_ctrl_t ctrl;
  mmf_pkg::mmf_sts_t  sts;

  // Size registers accept a word in every cycle.
  assign cfg_ready_o = 1'b1;

  mmf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .ctrl_o         (ctrl),
    .sts_i          (sts)
  );

  mmf_datapath #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .ctrl_i      (ctrl),
    .sts_o       (sts),
    .result_o    (result_o)
  );

  // A result strobe lasts exactly one cycle.
  `ASSERT_CLK(a_strobe_single, result_valid_o |=> !result_valid_o, "result strobe held")
  // An accepted command word makes the block busy in the next cycle.
  `ASSERT_CLK(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accept without busy")
  // A strobe is only shown while a command is in progress.
  `ASSERT_CLK(a_strobe_busy, result_valid_o |-> busy_o, "strobe while idle")
  // The sum is only taken once every product has reached the accumulator.
  `ASSERT_NEVER(a_early_load, ctrl.load_result && ctrl.use_acc && sts.pipe_busy, "early sum")

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// Fixed-point matrix multiply testbench
// Drives element writes and C reads through the command port, reprograms
// the size registers between phases, and checks every result word against
// a cycle-free prediction of the stores and the saturating dot product.
// ---------------------------------------------------------------------------
module tb;

  // The command port has a fourth kind that the block must ignore.
  localparam logic [1:0]                    KIND_UNUSED = 2'd3;
  // Index of the channel that maps to no size register.
  localparam logic [mmf_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  localparam int DIM          = mmf_pkg::MMF_MAX_DIM;
  localparam int TOTAL_ITEMS  = 1700;
  // This covers the longest C read at the largest inner dimension, so any word still in
  // flight, including an ignored one that has no result to wait for.
  localparam int SETTLE_CYCLES = 45;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  mmf_pkg::mmf_in_t              cmd_i;
  logic                          result_valid_o;
  mmf_pkg::mmf_out_t             result_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [mmf_pkg::CFG_W-1:0]     cfg_data_i;

  matrix_multiply_fixed uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the block's state: the three size registers and both
  // element stores. The written flags keep every C read on entries that
  // hold defined data, since the hardware stores are never cleared.
  logic [mmf_pkg::CFG_W-1:0] size_rows_a;
  logic [mmf_pkg::CFG_W-1:0] size_inner;
  logic [mmf_pkg::CFG_W-1:0] size_cols_b;
  logic signed [15:0]        a_elems [DIM*DIM];
  logic signed [15:0]        b_elems [DIM*DIM];
  bit                        a_written [DIM*DIM];
  bit                        b_written [DIM*DIM];

  mmf_pkg::mmf_out_t expected_results [$];
  mmf_pkg::mmf_out_t expected_word;
  int                fail_count;
  int                items_sent;
  int                cycle_count;
  int                sender_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The watchdog ends a run that hangs on a handshake.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // A size register above the store bound behaves as the bound.
  function automatic int clamp_size(input logic [mmf_pkg::CFG_W-1:0] v);
    return (v > DIM) ? DIM : int'(v);
  endfunction

  // Applies one accepted command word to the shadow state and returns the
  // result word it must produce. Kind three is never passed in here.
  function automatic mmf_pkg::mmf_out_t predict_response(input mmf_pkg::mmf_in_t cmd);
    mmf_pkg::mmf_out_t  res;
    int                 na;
    int                 nk;
    int                 nb;
    int                 row;
    int                 col;
    logic signed [63:0] acc;
    na  = clamp_size(size_rows_a);
    nk  = clamp_size(size_inner);
    nb  = clamp_size(size_cols_b);
    row = cmd.row_index;
    col = cmd.col_index;
    res = '0;
    case (cmd.kind)
      mmf_pkg::KIND_WRITE_A: begin
        if (row >= na || col >= nk) begin
          res.index_error = 1'b1;
        end else begin
          a_elems[row*DIM + col]   = cmd.element_value;
          a_written[row*DIM + col] = 1'b1;
        end
      end
      mmf_pkg::KIND_WRITE_B: begin
        if (row >= nk || col >= nb) begin
          res.index_error = 1'b1;
        end else begin
          b_elems[row*DIM + col]   = cmd.element_value;
          b_written[row*DIM + col] = 1'b1;
        end
      end
      default: begin
        if (row >= na || col >= nb) begin
          res.index_error = 1'b1;
        end else begin
          // Each product is exact Q16.16; the sum is exact before it is
          // clipped to the signed 32-bit range.
          acc = '0;
          for (int k = 0; k < nk; k++) begin
            acc = acc + longint'(a_elems[row*DIM + k]) * longint'(b_elems[k*DIM + col]);
          end
          if (acc > 64'sh0000_0000_7fff_ffff) begin
            res.product_value = mmf_pkg::SAT_MAX;
          end else if (acc < -64'sh0000_0000_8000_0000) begin
            res.product_value = mmf_pkg::SAT_MIN;
          end else begin
            res.product_value = acc[31:0];
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic mmf_pkg::mmf_in_t make_cmd(input logic [1:0] kind, input int row,
                                                input int col, input logic [15:0] value);
    mmf_pkg::mmf_in_t c;
    c.kind          = kind;
    c.row_index     = row[4:0];
    c.col_index     = col[4:0];
    c.element_value = value;
    return c;
  endfunction

  // Elements lean toward the corners of the Q8.8 range so that sums
  // reach the saturation limits now and then.
  function automatic logic [15:0] random_element();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // True when every operand of the requested C element has been written.
  function automatic bit operands_ready(input int row, input int col);
    int nk;
    nk = clamp_size(size_inner);
    for (int k = 0; k < nk; k++) begin
      if (!a_written[row*DIM + k] || !b_written[k*DIM + col]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Checks each result word in the cycle that it is strobed.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: product_value %0d, index_error %0b",
               result_o.product_value, result_o.index_error);
        fail_count++;
      end else begin
        expected_word = expected_results.pop_front();
        if (result_o.product_value !== expected_word.product_value) begin
          $error("product_value: expected %0d, actual %0d",
                 expected_word.product_value, result_o.product_value);
          fail_count++;
        end
        if (result_o.index_error !== expected_word.index_error) begin
          $error("index_error: expected %0b, actual %0b",
                 expected_word.index_error, result_o.index_error);
          fail_count++;
        end
      end
    end
  end

  // Sends one command word. The sender may first pause for a random number
  // of cycles; start stays high after acceptance until the next call drives
  // the following word or a pause lowers it.
  task automatic send_word(input mmf_pkg::mmf_in_t cmd);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    cmd_i   = cmd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (cmd.kind != KIND_UNUSED) begin
      expected_results.push_back(predict_response(cmd));
      items_sent++;
    end
  endtask

  // Lowers start, waits for every outstanding result, and lets an ignored
  // word that may still be in the pipeline finish.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [mmf_pkg::CFG_IDX_W-1:0] idx,
                            input logic [mmf_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mmf_pkg::CFG_ROWS_A:    size_rows_a = value;
      mmf_pkg::CFG_INNER_DIM: size_inner  = value;
      mmf_pkg::CFG_COLS_B:    size_cols_b = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_sizes(input logic [mmf_pkg::CFG_W-1:0] na,
                           input logic [mmf_pkg::CFG_W-1:0] nk,
                           input logic [mmf_pkg::CFG_W-1:0] nb);
    wait_idle();
    write_size(mmf_pkg::CFG_ROWS_A, na);
    write_size(mmf_pkg::CFG_INNER_DIM, nk);
    write_size(mmf_pkg::CFG_COLS_B, nb);
  endtask

  // Writes the operands of C(row, col) that are still missing, and rewrites
  // some of the others so that repeated reads see fresh data.
  task automatic fill_operands(input int row, input int col, input int rewrite_pct);
    int nk;
    nk = clamp_size(size_inner);
    for (int k = 0; k < nk; k++) begin
      if (!a_written[row*DIM + k] || $urandom_range(0, 99) < rewrite_pct)
        send_word(make_cmd(mmf_pkg::KIND_WRITE_A, row, k, random_element()));
      if (!b_written[k*DIM + col] || $urandom_range(0, 99) < rewrite_pct)
        send_word(make_cmd(mmf_pkg::KIND_WRITE_B, k, col, random_element()));
    end
  endtask

  // Reset leaves all three sizes at 32, so the far corner is in range.
  task automatic test_default_sizes();
    send_word(make_cmd(mmf_pkg::KIND_WRITE_A, 31, 31, 16'h8000));
    send_word(make_cmd(mmf_pkg::KIND_WRITE_B, 31, 31, 16'h7fff));
  endtask

  // Three products of the most negative element square to more than the
  // positive limit; against the most positive element they go below the
  // negative limit.
  task automatic test_saturating_products();
    set_sizes(6'd2, 6'd3, 6'd2);
    for (int k = 0; k < 3; k++) begin
      send_word(make_cmd(mmf_pkg::KIND_WRITE_A, 0, k, 16'h8000));
      send_word(make_cmd(mmf_pkg::KIND_WRITE_B, k, 0, 16'h8000));
      send_word(make_cmd(mmf_pkg::KIND_WRITE_B, k, 1, 16'h7fff));
    end
    send_word(make_cmd(mmf_pkg::KIND_READ_C, 0, 0, 16'h0000));
    send_word(make_cmd(mmf_pkg::KIND_READ_C, 0, 1, 16'hffff));
  endtask

  // Each bound of each kind, one index just past it.
  task automatic test_index_errors();
    send_word(make_cmd(mmf_pkg::KIND_WRITE_A, 2, 0, 16'h1234));
    send_word(make_cmd(mmf_pkg::KIND_WRITE_A, 0, 3, 16'h1234));
    send_word(make_cmd(mmf_pkg::KIND_WRITE_B, 3, 0, 16'h1234));
    send_word(make_cmd(mmf_pkg::KIND_WRITE_B, 0, 2, 16'h1234));
    send_word(make_cmd(mmf_pkg::KIND_READ_C, 2, 0, 16'h0000));
    send_word(make_cmd(mmf_pkg::KIND_READ_C, 0, 2, 16'h0000));
  endtask

  // The unused kind produces nothing; the read after it confirms that the
  // stores were left alone.
  task automatic test_ignored_kind();
    send_word(make_cmd(KIND_UNUSED, 0, 0, 16'h0100));
    send_word(make_cmd(mmf_pkg::KIND_READ_C, 0, 0, 16'h0000));
  endtask

  // A zero inner size rejects every element write but gives an empty sum
  // for a read; zero rows reject the read too.
  task automatic test_size_zero();
    set_sizes(6'd2, 6'd0, 6'd2);
    send_word(make_cmd(mmf_pkg::KIND_WRITE_A, 0, 0, 16'h0100));
    send_word(make_cmd(mmf_pkg::KIND_WRITE_B, 0, 0, 16'h0100));
    send_word(make_cmd(mmf_pkg::KIND_READ_C, 1, 1, 16'h0000));
    wait_idle();
    write_size(mmf_pkg::CFG_ROWS_A, 6'd0);
    send_word(make_cmd(mmf_pkg::KIND_READ_C, 0, 0, 16'h0000));
  endtask

  // All-ones sizes act as the store bound; the spare channel index is
  // written too and must change nothing.
  task automatic test_size_above_bound();
    set_sizes(6'h3f, 6'h3f, 6'h3f);
    write_size(CFG_UNUSED, 6'($urandom));
    send_word(make_cmd(mmf_pkg::KIND_WRITE_A, 31, 31, 16'h7fff));
    send_word(make_cmd(mmf_pkg::KIND_WRITE_B, 31, 31, 16'h8000));
  endtask

  function automatic logic [mmf_pkg::CFG_W-1:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return mmf_pkg::CFG_W'($urandom_range(1, 8));
    if (pick < 85) return mmf_pkg::CFG_W'($urandom_range(9, 32));
    if (pick < 96) return mmf_pkg::CFG_W'($urandom_range(33, 63));
    return '0;
  endfunction

  // Phases of random traffic. Most words belong to complete sequences that
  // load a row of A and a column of B and then read their product; the rest
  // are stray writes, stray reads and ignored words.
  task automatic test_random_traffic();
    int phase;
    int phase_end;
    int pick;
    int na;
    int nb;
    int row;
    int col;
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      set_sizes(random_size(), random_size(), random_size());
      case (phase % 3)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 56;
        default: sender_idle_pct = 14;
      endcase
      phase++;
      phase_end = items_sent + $urandom_range(40, 160);
      na = clamp_size(size_rows_a);
      nb = clamp_size(size_cols_b);
      while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 60 && na != 0 && nb != 0) begin
          row = $urandom_range(0, na - 1);
          col = $urandom_range(0, nb - 1);
          fill_operands(row, col, 30);
          send_word(make_cmd(mmf_pkg::KIND_READ_C, row, col, random_element()));
        end else if (pick < 85) begin
          send_word(make_cmd($urandom_range(0, 1) ? mmf_pkg::KIND_WRITE_B
                                                  : mmf_pkg::KIND_WRITE_A,
                             $urandom_range(0, 31), $urandom_range(0, 31),
                             random_element()));
        end else if (pick < 95) begin
          row = $urandom_range(0, 31);
          col = $urandom_range(0, 31);
          // An in-range read must never touch an unwritten entry.
          if (row < na && col < nb && !operands_ready(row, col))
            fill_operands(row, col, 0);
          send_word(make_cmd(mmf_pkg::KIND_READ_C, row, col, random_element()));
        end else begin
          send_word(make_cmd(KIND_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                             random_element()));
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cmd_i           = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    fail_count      = 0;
    items_sent      = 0;
    sender_idle_pct = 0;
    size_rows_a     = mmf_pkg::CFG_RESET;
    size_inner      = mmf_pkg::CFG_RESET;
    size_cols_b     = mmf_pkg::CFG_RESET;
    for (int i = 0; i < DIM*DIM; i++) begin
      a_elems[i]   = '0;
      b_elems[i]   = '0;
      a_written[i] = 1'b0;
      b_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_sizes();
    test_saturating_products();
    test_index_errors();
    test_ignored_kind();
    test_size_zero();
    test_size_above_bound();
    test_random_traffic();

    // Any word strobed during the settle time with nothing expected is
    // flagged by the checker.
    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
